// ===== hw/rtl/sscp_pkg.sv =====
// Shared types and constants for the shadow slice cache policy block.
package sscp_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
   localparam logic [15:0] EVICT_AFTER_RESET = 16'd240;
   localparam logic [9:0]  SWEEP_MASK_RESET  = 10'd63;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_QUERY   = 2'd1;
   localparam logic [1:0] OP_CAPTURE = 2'd2;
   localparam logic [1:0] OP_BLIT    = 2'd3;

   localparam logic [1:0] RSN_NONE    = 2'd0;
   localparam logic [1:0] RSN_NEW     = 2'd1;
   localparam logic [1:0] RSN_SIG     = 2'd2;
   localparam logic [1:0] RSN_NOLAYER = 2'd3;

   localparam logic CSR_EVICT_AFTER = 1'b0;
   localparam logic CSR_SWEEP_MASK  = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] camera_tag;
      logic        camera_present;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [63:0] static_sig;
   } req_word_type;

   typedef struct packed {
      logic       render_fresh;
      logic [1:0] reason;
      logic       layer_hit;
      logic [5:0] layer;
      logic       units_full;
      logic       layers_full;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HASH,
      ST_MUL,
      ST_USCAN,
      ST_UDECIDE,
      ST_LSCAN,
      ST_LDECIDE,
      ST_SWEEP,
      ST_RESP
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;        // latch request word
      logic hash_init;   // seed the hash
      logic hash_xor;    // fold next position word
      logic hash_mul;    // multiply by prime
      logic uscan_start; // reset unit scan
      logic uscan_step;  // examine one unit entry
      logic udecide;     // resolve the query's unit outcome
      logic lscan_start; // reset layer scan
      logic lscan_step;  // examine one layer entry
      logic ldecide;     // resolve layer outcome
      logic tick;        // advance frame count
      logic sweep_step;  // age one unit entry
      logic rsp_load;    // capture result word
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] op;
      logic       present;
      logic       hash_last;   // third word folded
      logic       mul_done;
      logic       uscan_done;
      logic       uscan_hit_settled; // query ends at unit decision
      logic       lscan_done;
      logic       sweep_due;
      logic       sweep_done;
   } dp_status_type;

endpackage

// ===== hw/rtl/shadow_slice_cache_policy.sv =====
// Top level of the shadow slice cache policy block.
// A frame tick runs a sweep on a sweep frame; a render query hashes the position (only
//   when the camera is present), scans the unit table and may scan the bound layers;
//   capture and blit scan the bound layers. One word is in flight at a time.
// The unit scan over the key RAM, one entry per cycle, sets the query rate.
// Reset (synchronous, active high) clears unit and layer valid bits, the frame
//   counter, the layer allocator and the registers to 240 and 63.
module shadow_slice_cache_policy #(
   parameter int UNIT_ENTRIES = 128,
   parameter int LAYERS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sscp_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sscp_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [15:0]            csr_data
);
   sscp_pkg::ctl_cmd_type   cmd;
   sscp_pkg::dp_status_type status;

   // Hold the controller apart from the datapath: only commands and status cross.
   sscp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd));

   sscp_dp #(.UNIT_ENTRIES(UNIT_ENTRIES), .LAYERS(LAYERS)) u_dp (
      .clock(clock), .reset(reset), .req_word(req_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .status(status), .rsp_word(rsp_word));
endmodule

// ===== hw/rtl/sscp_ram.sv =====
// Generic single-port RAM with registered read.
module sscp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== hw/rtl/sscp_ctrl.sv =====
// Controller state machine sequencing hashing, scans and sweeps.
module sscp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  sscp_pkg::dp_status_type status,
   output sscp_pkg::ctl_cmd_type   cmd
);
   sscp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sscp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sscp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sscp_pkg::ST_HASH;
            end
         end
         sscp_pkg::ST_HASH: begin
            case (status.op)
               sscp_pkg::OP_TICK: state_in = sscp_pkg::ST_SWEEP;
               sscp_pkg::OP_QUERY: begin
                  state_in = status.present ? sscp_pkg::ST_MUL : sscp_pkg::ST_USCAN;
               end
               default: state_in = sscp_pkg::ST_LSCAN;
            endcase
         end
         sscp_pkg::ST_MUL: begin
            if (status.mul_done) begin
               state_in = status.hash_last ? sscp_pkg::ST_USCAN : sscp_pkg::ST_MUL;
            end
         end
         sscp_pkg::ST_USCAN: begin
            if (status.uscan_done) begin
               state_in = sscp_pkg::ST_UDECIDE;
            end
         end
         sscp_pkg::ST_UDECIDE: begin
            state_in = status.uscan_hit_settled ? sscp_pkg::ST_RESP : sscp_pkg::ST_LSCAN;
         end
         sscp_pkg::ST_LSCAN: begin
            if (status.lscan_done) begin
               state_in = sscp_pkg::ST_LDECIDE;
            end
         end
         sscp_pkg::ST_LDECIDE: state_in = sscp_pkg::ST_RESP;
         sscp_pkg::ST_SWEEP: begin
            if (!status.sweep_due || status.sweep_done) begin
               state_in = sscp_pkg::ST_RESP;
            end
         end
         sscp_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = sscp_pkg::ST_IDLE;
            end
         end
         default: state_in = sscp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != sscp_pkg::ST_IDLE);
      rsp_valid = (state_ff == sscp_pkg::ST_RESP);
      case (state_ff)
         sscp_pkg::ST_IDLE: cmd.load = req_valid;
         sscp_pkg::ST_HASH: begin
            cmd.hash_init = 1'b1;
            cmd.uscan_start = 1'b1;
            cmd.lscan_start = 1'b1;
            cmd.tick = (status.op == sscp_pkg::OP_TICK);
         end
         sscp_pkg::ST_MUL: begin
            cmd.hash_mul = 1'b1;
            cmd.hash_xor = status.mul_done && !status.hash_last;
         end
         sscp_pkg::ST_USCAN: cmd.uscan_step = 1'b1;
         sscp_pkg::ST_UDECIDE: cmd.udecide = 1'b1;
         sscp_pkg::ST_LSCAN: cmd.lscan_step = 1'b1;
         sscp_pkg::ST_LDECIDE: cmd.ldecide = 1'b1;
         sscp_pkg::ST_SWEEP: cmd.sweep_step = status.sweep_due;
         sscp_pkg::ST_RESP: cmd.rsp_load = 1'b0;
         default: cmd = '0;
      endcase
   end
endmodule

// ===== hw/rtl/sscp_dp.sv =====
// Datapath: hash unit, unit table, layer table, frame counter and result word.
module sscp_dp #(
   parameter int UNIT_ENTRIES = 128,
   parameter int LAYERS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sscp_pkg::req_word_type  req_word,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [15:0]             csr_data,
   input  sscp_pkg::ctl_cmd_type   cmd,
   output sscp_pkg::dp_status_type status,
   output sscp_pkg::rsp_word_type  rsp_word
);
   localparam int UW = $clog2(UNIT_ENTRIES);
   localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int LCW = $clog2(LAYERS + 1);

   sscp_pkg::req_word_type req_ff;
   logic [15:0] evict_after_ff;
   logic [9:0]  sweep_mask_ff;
   logic [31:0] frame_ff;

   // Hash: fold a word, then multiply as one 32x32 low product plus two cross terms,
   // stepping through phase 0..3.
   logic [63:0] hash_ff;
   logic [1:0]  word_ff;    // words folded so far minus one
   logic [1:0]  phase_ff;
   logic [63:0] acc_ff;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   always_comb begin
      case (phase_ff)
         2'd0: begin mul_a = hash_ff[31:0];  mul_b = sscp_pkg::FNV_PRIME[31:0]; end
         2'd1: begin mul_a = hash_ff[63:32]; mul_b = sscp_pkg::FNV_PRIME[31:0]; end
         2'd2: begin mul_a = hash_ff[31:0];  mul_b = sscp_pkg::FNV_PRIME[63:32]; end
         default: begin mul_a = 32'd0; mul_b = 32'd0; end
      endcase
      mul_p = {32'd0, mul_a} * {32'd0, mul_b};
   end

   logic [31:0] next_word;
   always_comb begin
      case (word_ff)
         2'd0: next_word = req_ff.pos_y;
         default: next_word = req_ff.pos_z;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.hash_init) begin
         hash_ff  <= req_ff.camera_present ?
                     (sscp_pkg::FNV_BASIS ^ {32'd0, req_ff.pos_x}) : sscp_pkg::FNV_BASIS;
         word_ff  <= 2'd0;
         phase_ff <= 2'd0;
         acc_ff   <= '0;
      end else if (cmd.hash_mul) begin
         case (phase_ff)
            2'd0: acc_ff <= mul_p;
            2'd1: acc_ff <= acc_ff + {mul_p[31:0], 32'd0};
            2'd2: acc_ff <= acc_ff + {mul_p[31:0], 32'd0};
            default: acc_ff <= acc_ff;
         endcase
         phase_ff <= phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            if (cmd.hash_xor) begin
               hash_ff <= acc_ff ^ {32'd0, next_word};
               word_ff <= word_ff + 2'd1;
            end else begin
               hash_ff <= acc_ff;
            end
         end
      end
   end

   // Unit table: valid bits in flops, payload in RAMs.
   logic [UNIT_ENTRIES-1:0] uvalid_ff;
   logic [UW:0]   uidx_ff;   // address presented this cycle
   logic [UW:0]   uchk_ff;   // address whose data is visible now
   logic          uchk_vld_ff;
   logic          ufound_ff, ufree_ff;
   logic [UW-1:0] uslot_ff, ufree_slot_ff;
   logic [63:0]   ukey_rd, usig_rd;
   logic [31:0]   useen_rd;
   logic          uwr_key, uwr_sig, uwr_seen;
   logic [UW-1:0] uaddr;
   logic [63:0]   usig_wdata;
   logic [31:0]   useen_wdata;
   logic          sweep_run;
   logic          sig_match_ff;

   // Sweep reuses the scan address; the evict decision lands in the cycle after the address.
   logic [31:0] age;
   assign age = frame_ff - useen_rd;

   always_comb begin
      uaddr = uidx_ff[UW-1:0];
      uwr_key = 1'b0;
      uwr_sig = 1'b0;
      uwr_seen = 1'b0;
      usig_wdata = req_ff.static_sig;
      useen_wdata = frame_ff;
      if (cmd.udecide) begin
         if (ufound_ff) begin
            uaddr = uslot_ff;
            uwr_seen = 1'b1;
            uwr_sig = 1'b1;
         end else if (ufree_ff) begin
            uaddr = ufree_slot_ff;
            uwr_key = 1'b1;
            uwr_sig = 1'b1;
            uwr_seen = 1'b1;
         end
      end
   end

   sscp_ram #(.WIDTH(64), .DEPTH(UNIT_ENTRIES)) u_key_ram (
      .clock(clock), .wr_en(uwr_key), .addr(uaddr), .wr_data(hash_ff), .rd_data(ukey_rd));
   sscp_ram #(.WIDTH(64), .DEPTH(UNIT_ENTRIES)) u_sig_ram (
      .clock(clock), .wr_en(uwr_sig), .addr(uaddr), .wr_data(usig_wdata), .rd_data(usig_rd));
   sscp_ram #(.WIDTH(32), .DEPTH(UNIT_ENTRIES)) u_seen_ram (
      .clock(clock), .wr_en(uwr_seen), .addr(uaddr), .wr_data(useen_wdata),
      .rd_data(useen_rd));

   logic [UW:0] ulast;
   assign ulast = UNIT_ENTRIES[UW:0];
   assign sweep_run = ((frame_ff & {22'd0, sweep_mask_ff}) == 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         uvalid_ff <= '0;
      end else if (cmd.udecide && !ufound_ff && ufree_ff) begin
         uvalid_ff[ufree_slot_ff] <= 1'b1;
      end else if (cmd.sweep_step && uchk_vld_ff) begin
         if (uvalid_ff[uchk_ff[UW-1:0]] && (age > {16'd0, evict_after_ff})) begin
            uvalid_ff[uchk_ff[UW-1:0]] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.uscan_start) begin
         uidx_ff <= '0;
         uchk_vld_ff <= 1'b0;
         ufound_ff <= 1'b0;
         ufree_ff <= 1'b0;
      end else if (cmd.uscan_step || cmd.sweep_step) begin
         if (uidx_ff != ulast) begin
            uidx_ff <= uidx_ff + 1'b1;
         end
         uchk_ff <= uidx_ff;
         uchk_vld_ff <= (uidx_ff != ulast);
         if (cmd.uscan_step && uchk_vld_ff) begin
            if (uvalid_ff[uchk_ff[UW-1:0]]) begin
               if (!ufound_ff && ukey_rd == hash_ff) begin
                  ufound_ff <= 1'b1;
                  uslot_ff <= uchk_ff[UW-1:0];
                  sig_match_ff <= (usig_rd == req_ff.static_sig);
               end
            end else if (!ufree_ff) begin
               ufree_ff <= 1'b1;
               ufree_slot_ff <= uchk_ff[UW-1:0];
            end
         end
      end
   end

   assign status.uscan_done = uchk_vld_ff && (uchk_ff == ulast - 1'b1);
   assign status.sweep_done = status.uscan_done;
   assign status.sweep_due = sweep_run;
   assign status.uscan_hit_settled = !(ufound_ff && sig_match_ff);

   // Layer table: bound tags in a RAM, valid bits in flops.
   logic [LAYERS-1:0] lvalid_ff;
   logic [LCW-1:0] next_free_ff;
   logic [LCW-1:0] lidx_ff, lchk_ff;
   logic           lchk_vld_ff;
   logic           lfound_ff;
   logic [LW-1:0]  lslot_ff;
   logic [31:0]    lcam_rd;
   logic           lcam_wr;
   logic [LW-1:0]  laddr;

   assign lcam_wr = cmd.ldecide && (req_ff.op == sscp_pkg::OP_CAPTURE) && !lfound_ff &&
                    (next_free_ff != LAYERS[LCW-1:0]);
   assign laddr = lcam_wr ? next_free_ff[LW-1:0] : lidx_ff[LW-1:0];

   sscp_ram #(.WIDTH(32), .DEPTH(LAYERS)) u_cam_ram (
      .clock(clock), .wr_en(lcam_wr), .addr(laddr), .wr_data(req_ff.camera_tag),
      .rd_data(lcam_rd));

   always_ff @(posedge clock) begin
      if (cmd.lscan_start) begin
         lidx_ff <= '0;
         lchk_vld_ff <= 1'b0;
         lfound_ff <= 1'b0;
      end else if (cmd.lscan_step) begin
         if (lidx_ff != next_free_ff) begin
            lidx_ff <= lidx_ff + 1'b1;
         end
         lchk_ff <= lidx_ff;
         lchk_vld_ff <= (lidx_ff != next_free_ff);
         if (lchk_vld_ff && !lfound_ff && lcam_rd == req_ff.camera_tag) begin
            lfound_ff <= 1'b1;
            lslot_ff <= lchk_ff[LW-1:0];
         end
      end
   end

   // Done once the cursor has reached the bound count and the last read was checked.
   assign status.lscan_done = (lidx_ff == next_free_ff) && !lchk_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lvalid_ff <= '0;
         next_free_ff <= '0;
      end else if (cmd.ldecide && req_ff.op == sscp_pkg::OP_CAPTURE) begin
         if (lfound_ff) begin
            lvalid_ff[lslot_ff] <= 1'b1;
         end else if (next_free_ff != LAYERS[LCW-1:0]) begin
            lvalid_ff[next_free_ff[LW-1:0]] <= 1'b1;
            next_free_ff <= next_free_ff + 1'b1;
         end
      end
   end

   // Registers and frame counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         evict_after_ff <= sscp_pkg::EVICT_AFTER_RESET;
         sweep_mask_ff <= sscp_pkg::SWEEP_MASK_RESET;
         frame_ff <= '0;
      end else begin
         if (csr_write && csr_index == sscp_pkg::CSR_EVICT_AFTER) begin
            evict_after_ff <= csr_data;
         end
         if (csr_write && csr_index == sscp_pkg::CSR_SWEEP_MASK) begin
            sweep_mask_ff <= csr_data[9:0];
         end
         if (cmd.tick) begin
            frame_ff <= frame_ff + 32'd1;
         end
      end
   end

   // Result word.
   logic [5:0] lslot6;
   assign lslot6 = 6'(lslot_ff);

   always_ff @(posedge clock) begin
      if (cmd.hash_init) begin
         rsp_word <= '0;
      end else if (cmd.udecide) begin
         if (!ufound_ff) begin
            rsp_word.render_fresh <= 1'b1;
            rsp_word.reason <= sscp_pkg::RSN_NEW;
            rsp_word.units_full <= !ufree_ff;
         end else if (!sig_match_ff) begin
            rsp_word.render_fresh <= 1'b1;
            rsp_word.reason <= sscp_pkg::RSN_SIG;
         end
      end else if (cmd.ldecide) begin
         case (req_ff.op)
            sscp_pkg::OP_QUERY: begin
               if (lfound_ff && lvalid_ff[lslot_ff]) begin
                  rsp_word.layer_hit <= 1'b1;
                  rsp_word.layer <= lslot6;
               end else begin
                  rsp_word.render_fresh <= 1'b1;
                  rsp_word.reason <= sscp_pkg::RSN_NOLAYER;
               end
            end
            sscp_pkg::OP_CAPTURE: begin
               if (lfound_ff) begin
                  rsp_word.layer_hit <= 1'b1;
                  rsp_word.layer <= lslot6;
               end else if (next_free_ff != LAYERS[LCW-1:0]) begin
                  rsp_word.layer_hit <= 1'b1;
                  rsp_word.layer <= 6'(next_free_ff);
               end else begin
                  rsp_word.layers_full <= 1'b1;
               end
            end
            sscp_pkg::OP_BLIT: begin
               if (lfound_ff && lvalid_ff[lslot_ff]) begin
                  rsp_word.layer_hit <= 1'b1;
                  rsp_word.layer <= lslot6;
               end
            end
            default: rsp_word <= rsp_word;
         endcase
      end
   end

   assign status.op = req_ff.op;
   assign status.present = req_ff.camera_present;
   assign status.hash_last = (word_ff == 2'd2);
   assign status.mul_done = (phase_ff == 2'd3);
endmodule

// ===== hw/rtl/sscp_checker.sv =====
// Port-level checker for the shadow slice cache policy block, with its bind.
module sscp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sscp_pkg::rsp_word_type rsp_word
);
   // A result word holds while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // No new word is taken while a result waits.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");

   // A reuse answer carries no reason.
   a_reuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.render_fresh && rsp_word.reason != sscp_pkg::RSN_NONE |-> 1'b0)
      else $error("reason set on reuse");

   // A full unit table only accompanies a new-unit answer.
   a_ufull: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.units_full |-> rsp_word.reason == sscp_pkg::RSN_NEW)
      else $error("units_full without new unit");
endmodule

bind shadow_slice_cache_policy sscp_checker u_sscp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word));

// ===== sim/shadow_slice_cache_policy_tb.sv =====
// Testbench for the shadow slice cache policy block: random and directed events.
`timescale 1ns / 1ps

class slice_policy_board;
   // predictor state
   logic [15:0] evict_after;
   logic [9:0]  sweep_mask;
   bit          unit_valid[128];
   logic [63:0] unit_key[128];
   logic [63:0] unit_sig[128];
   logic [31:0] unit_seen[128];
   logic [31:0] frame_count;
   logic [31:0] layer_cam[64];
   bit          layer_valid[64];
   int          next_layer;
   sscp_pkg::rsp_word_type pending[$];
   int          mismatches;

   function void clear();
      evict_after = sscp_pkg::EVICT_AFTER_RESET;
      sweep_mask = sscp_pkg::SWEEP_MASK_RESET;
      foreach (unit_valid[i]) unit_valid[i] = 0;
      foreach (layer_valid[i]) layer_valid[i] = 0;
      frame_count = 0;
      next_layer = 0;
      pending.delete();
      mismatches = 0;
   endfunction

   function void set_reg(logic idx, logic [15:0] val);
      if (idx == sscp_pkg::CSR_EVICT_AFTER) evict_after = val;
      else sweep_mask = val[9:0];
   endfunction

   function int bound_layer(logic [31:0] tag);
      for (int l = 0; l < next_layer; l++)
         if (layer_cam[l] == tag) return l;
      return -1;
   endfunction

   function void note_request(sscp_pkg::req_word_type w);
      sscp_pkg::rsp_word_type r;
      logic [63:0] key;
      int slot, free_slot, l;
      r = '0;
      case (w.op)
         sscp_pkg::OP_TICK: begin
            frame_count = frame_count + 32'd1;
            if ((frame_count & {22'd0, sweep_mask}) == 32'd0)
               for (int i = 0; i < 128; i++)
                  if (unit_valid[i] && (frame_count - unit_seen[i]) > {16'd0, evict_after})
                     unit_valid[i] = 0;
         end
         sscp_pkg::OP_QUERY: begin
            key = sscp_pkg::FNV_BASIS;
            if (w.camera_present) begin
               key = (key ^ {32'd0, w.pos_x}) * sscp_pkg::FNV_PRIME;
               key = (key ^ {32'd0, w.pos_y}) * sscp_pkg::FNV_PRIME;
               key = (key ^ {32'd0, w.pos_z}) * sscp_pkg::FNV_PRIME;
            end
            slot = -1;
            free_slot = -1;
            for (int i = 0; i < 128; i++)
               if (unit_valid[i]) begin
                  if (slot < 0 && unit_key[i] == key) slot = i;
               end else if (free_slot < 0) free_slot = i;
            if (slot < 0) begin
               r.render_fresh = 1;
               r.reason = sscp_pkg::RSN_NEW;
               if (free_slot < 0) r.units_full = 1;
               else begin
                  unit_valid[free_slot] = 1;
                  unit_key[free_slot] = key;
                  unit_sig[free_slot] = w.static_sig;
                  unit_seen[free_slot] = frame_count;
               end
            end else begin
               unit_seen[slot] = frame_count;
               if (unit_sig[slot] != w.static_sig) begin
                  unit_sig[slot] = w.static_sig;
                  r.render_fresh = 1;
                  r.reason = sscp_pkg::RSN_SIG;
               end else begin
                  l = bound_layer(w.camera_tag);
                  if (l < 0 || !layer_valid[l]) begin
                     r.render_fresh = 1;
                     r.reason = sscp_pkg::RSN_NOLAYER;
                  end else begin
                     r.layer_hit = 1;
                     r.layer = l[5:0];
                  end
               end
            end
         end
         sscp_pkg::OP_CAPTURE: begin
            l = bound_layer(w.camera_tag);
            if (l < 0) begin
               if (next_layer >= 64) r.layers_full = 1;
               else begin
                  l = next_layer;
                  layer_cam[l] = w.camera_tag;
                  next_layer++;
               end
            end
            if (l >= 0) begin
               layer_valid[l] = 1;
               r.layer_hit = 1;
               r.layer = l[5:0];
            end
         end
         default: begin
            l = bound_layer(w.camera_tag);
            if (l >= 0 && layer_valid[l]) begin
               r.layer_hit = 1;
               r.layer = l[5:0];
            end
         end
      endcase
      pending.push_back(r);
   endfunction

   function void check_result(sscp_pkg::rsp_word_type got);
      sscp_pkg::rsp_word_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h got %h", want, got);
      end
   endfunction
endclass

module shadow_slice_cache_policy_tb;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   sscp_pkg::req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   sscp_pkg::rsp_word_type rsp_word;
   logic         csr_write = 0;
   logic         csr_index = 0;
   logic [15:0]  csr_data = '0;

   slice_policy_board board;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_off = 0;
   logic [31:0] cam_pool[8];
   logic [31:0] pos_pool[12];
   logic [63:0] sig_pool[3];

   shadow_slice_cache_policy uut (.*);

   always #10 clock = ~clock;

   // Receiver: random stall, or a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_word);
   end

   // Offer one word, with optional idle gaps before it; hold until accepted.
   task automatic send_word(sscp_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      board.note_request(w);
   endtask

   // Drop valid, wait until every result is back, then let the block settle.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      board.set_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic sscp_pkg::req_word_type rand_word(bit wellformed);
      sscp_pkg::req_word_type w;
      w.op = 2'($urandom_range(3));
      w.camera_tag = wellformed ? cam_pool[$urandom_range(7)] : $urandom();
      w.camera_present = ($urandom_range(9) != 0);
      w.pos_x = wellformed ? pos_pool[$urandom_range(11)] : $urandom();
      w.pos_y = wellformed ? pos_pool[$urandom_range(11)] : $urandom();
      w.pos_z = wellformed ? pos_pool[$urandom_range(11)] : $urandom();
      w.static_sig = wellformed ? sig_pool[$urandom_range(2)] : {$urandom(), $urandom()};
      return w;
   endfunction

   function automatic sscp_pkg::req_word_type make(logic [1:0] op, logic [31:0] tag,
                                                   logic pres, logic [31:0] p,
                                                   logic [63:0] sig);
      sscp_pkg::req_word_type w;
      w = '{op, tag, pres, p, ~p, p, sig};
      return w;
   endfunction

   task automatic random_phase(int count, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++) send_word(rand_word($urandom_range(9) < 8));
   endtask

   initial begin
      board = new();
      board.clear();
      foreach (cam_pool[i]) cam_pool[i] = $urandom();
      foreach (pos_pool[i]) pos_pool[i] = $urandom();
      foreach (sig_pool[i]) sig_pool[i] = {$urandom(), $urandom()};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: tick, new unit, reuse without layer, capture, reuse, sig change,
      // absent camera, blit hit and miss, field extremes.
      send_word(make(sscp_pkg::OP_TICK, 32'd0, 1'b0, 32'd0, 64'd0));
      send_word(make(sscp_pkg::OP_BLIT, 32'hffffffff, 1'b1, 32'hffffffff, '1));
      send_word(make(sscp_pkg::OP_QUERY, 32'd7, 1'b1, 32'd0, 64'h0));
      send_word(make(sscp_pkg::OP_QUERY, 32'd7, 1'b1, 32'd0, 64'h0));
      send_word(make(sscp_pkg::OP_CAPTURE, 32'd7, 1'b1, 32'd0, 64'd0));
      send_word(make(sscp_pkg::OP_QUERY, 32'd7, 1'b1, 32'd0, 64'h0));
      send_word(make(sscp_pkg::OP_QUERY, 32'd7, 1'b1, 32'd0, '1));
      send_word(make(sscp_pkg::OP_QUERY, 32'hffffffff, 1'b0, 32'hffffffff, '1));
      send_word(make(sscp_pkg::OP_QUERY, 32'hffffffff, 1'b0, 32'h12345678, '1));
      send_word(make(sscp_pkg::OP_BLIT, 32'd7, 1'b0, 32'd0, 64'd0));
      send_word(make(sscp_pkg::OP_CAPTURE, 32'hffffffff, 1'b0, 32'd0, 64'd0));
      send_word(make(sscp_pkg::OP_BLIT, 32'hffffffff, 1'b1, 32'd0, 64'd0));
      send_word(make(sscp_pkg::OP_BLIT, 32'd8, 1'b1, 32'd0, 64'd0));
      drain();

      // Fill the layer allocator and the unit table.
      write_reg(sscp_pkg::CSR_EVICT_AFTER, 16'hffff);
      write_reg(sscp_pkg::CSR_SWEEP_MASK, 16'h3ff);
      for (int n = 0; n < 66; n++)
         send_word(make(sscp_pkg::OP_CAPTURE, 32'(100 + n), 1'b1, 32'd0, 64'd0));
      for (int n = 0; n < 132; n++)
         send_word(make(sscp_pkg::OP_QUERY, 32'd1, 1'b1, $urandom(), 64'd5));
      send_word(make(sscp_pkg::OP_BLIT, 32'd165, 1'b1, 32'd0, 64'd0));
      drain();

      // Aggressive eviction: every frame sweeps, age limit zero.
      write_reg(sscp_pkg::CSR_EVICT_AFTER, 16'd0);
      write_reg(sscp_pkg::CSR_SWEEP_MASK, 16'd0);
      send_word(make(sscp_pkg::OP_TICK, 32'd0, 1'b0, 32'd0, 64'd0));
      send_word(make(sscp_pkg::OP_TICK, 32'd0, 1'b0, 32'd0, 64'd0));
      random_phase(300, 0, 0);
      drain();

      write_reg(sscp_pkg::CSR_EVICT_AFTER, 16'd3);
      write_reg(sscp_pkg::CSR_SWEEP_MASK, 16'd1);
      random_phase(300, 74, 0);
      drain();

      write_reg(sscp_pkg::CSR_EVICT_AFTER, 16'd20);
      write_reg(sscp_pkg::CSR_SWEEP_MASK, 16'd3);
      random_phase(300, 0, 74);
      drain();

      write_reg(sscp_pkg::CSR_EVICT_AFTER, sscp_pkg::EVICT_AFTER_RESET);
      write_reg(sscp_pkg::CSR_SWEEP_MASK, 16'h2aa);
      random_phase(300, 19, 19);

      // Long receiver hold-off while the sender keeps offering.
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         random_phase(20, 0, 0);
      join
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #100ms;
      $display("tb: failure");
      $finish;
   end
endmodule
